// ----- sv/prwd_pkg.sv -----
// ----------------------------------------------------------------------------
// prwd_pkg
// Types, codes and the module mapping table of the pixel readout word decoder.
// ----------------------------------------------------------------------------
package prwd_pkg;

   // item kinds on the request channel
   localparam logic [1:0] KIND_PAYLOAD = 2'd0;
   localparam logic [1:0] KIND_START   = 2'd1;
   localparam logic [1:0] KIND_END     = 2'd2;

   // word types, bits 15:14 of a payload word
   localparam logic [1:0] WTYPE_TRAILER = 2'b00;
   localparam logic [1:0] WTYPE_HEADER  = 2'b01;
   localparam logic [1:0] WTYPE_HIT     = 2'b10;
   localparam logic [1:0] WTYPE_FILL    = 2'b11;

   // error flag bits
   localparam logic [11:0] ERR_HDR_MISS   = 12'h001;
   localparam logic [11:0] ERR_TRL_MISS   = 12'h002;
   localparam logic [11:0] ERR_ORPHAN_TRL = 12'h004;
   localparam logic [11:0] ERR_HDR_CNT    = 12'h008;
   localparam logic [11:0] ERR_TRL_CNT    = 12'h010;
   localparam logic [11:0] ERR_FILL_UNEXP = 12'h020;
   localparam logic [11:0] ERR_FILL_MISS  = 12'h040;
   localparam logic [11:0] ERR_HITS       = 12'h080;
   localparam logic [11:0] ERR_EVT        = 12'h100;
   localparam logic [11:0] ERR_EQ         = 12'h200;
   localparam logic [11:0] ERR_HS         = 12'h400;
   localparam logic [11:0] ERR_CHIP       = 12'h800;

   localparam logic [4:0]  EqMax        = 5'd19;
   localparam logic [4:0]  EqRowSplit   = 5'd10;
   localparam logic [3:0]  ChipMax      = 4'd9;
   localparam logic [3:0]  ChipsPerHalf = 4'd5;
   localparam logic [2:0]  StaveMax     = 3'd5;
   localparam logic [7:0]  HeaderSat    = 8'hFF;
   localparam logic [12:0] HitSat       = 13'h1FFF;
   localparam logic [7:0]  OuterBase    = 8'd80;

   localparam logic [3:0] InnerOff [4] = '{4'd0, 4'd1, 4'd4, 4'd5};
   localparam logic [3:0] OuterOff [8] = '{4'd0, 4'd1, 4'd4, 4'd5,
                                          4'd8, 4'd9, 4'd12, 4'd13};

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] word;
      logic [4:0]  equipment;
      logic [5:0]  absent_mask;
      logic        new_event;
   } item_type;

   typedef struct packed {
      logic        hit_valid;
      logic [7:0]  module_res;
      logic [7:0]  column;
      logic [7:0]  pixel_row;
      logic [11:0] error_flags;
   } result_type;

   // offline module of equipment eq (0..19) and chip slot (0..11)
   function automatic logic [7:0] module_of(logic [4:0] eq, logic [3:0] slot);
      logic [3:0] r;
      logic [7:0] o;
      logic [7:0] m;
      if (eq >= EqRowSplit) begin
         r = 4'(eq - EqRowSplit);
         o = 8'd2;
      end else begin
         r = eq[3:0];
         o = 8'd0;
      end
      if (slot < 4'd4) begin
         m = {1'b0, r, 3'b000} + o + {4'b0000, InnerOff[slot[1:0]]};
      end else begin
         m = OuterBase + {r, 4'b0000} + o + {4'b0000, OuterOff[3'(slot - 4'd4)]};
      end
      return m;
   endfunction

endpackage

// ----- sv/pixel_readout_word_decoder.sv -----
// ----------------------------------------------------------------------------
// pixel_readout_word_decoder
// Input register, decode core and result register for the readout stream.
// ----------------------------------------------------------------------------
// Path: an accepted word is loaded into the input register, and from there into
// the result register once that register is empty or being drained.
// Throughput: one word per cycle while rsp_stall is low; the decode core
// updates its state in the same cycle the item moves into the result register.
// Reset: synchronous; clears both valid bits and all framing state.
// ----------------------------------------------------------------------------
module pixel_readout_word_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_kind,
   input  logic [15:0] req_word,
   input  logic [4:0]  req_equipment,
   input  logic [5:0]  req_absent_mask,
   input  logic        req_new_event,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_hit_valid,
   output logic [7:0]  rsp_module_res,
   output logic [7:0]  rsp_column,
   output logic [7:0]  rsp_pixel_row,
   output logic [11:0] rsp_error_flags
);
   import prwd_pkg::*;

   logic       s1_valid_ff, s1_valid_in;
   item_type   item_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type result_ff;
   result_type core_result;
   logic       advance;
   logic       req_accept;

   // stage 1 moves on when the result register is empty or being drained
   assign advance    = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = s1_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;

   assign s1_valid_in  = req_accept || (s1_valid_ff && !advance);
   assign rsp_valid_in = (s1_valid_ff && advance) || (rsp_valid_ff && rsp_stall);

   prwd_core u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (s1_valid_ff && advance),
      .item   (item_ff),
      .result (core_result)
   );

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         item_ff.kind        <= req_kind;
         item_ff.word        <= req_word;
         item_ff.equipment   <= req_equipment;
         item_ff.absent_mask <= req_absent_mask;
         item_ff.new_event   <= req_new_event;
      end
      if (s1_valid_ff && advance) result_ff <= core_result;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hit_valid   = result_ff.hit_valid;
   assign rsp_module_res  = result_ff.module_res;
   assign rsp_column      = result_ff.column;
   assign rsp_pixel_row   = result_ff.pixel_row;
   assign rsp_error_flags = result_ff.error_flags;

   // a hit beat can carry only the missing-header flag
   a_hit_errors: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit_valid |-> rsp_error_flags[11:1] == 11'd0)
      else $error("hit beat carries a non-hit error flag");

   // mapped module stays inside the table
   a_module_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit_valid |-> rsp_module_res <= 8'd239)
      else $error("module number out of range");

   // non-hit beats carry zero coordinates
   a_nonhit_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit_valid |->
         rsp_module_res == 8'd0 && rsp_column == 8'd0 && rsp_pixel_row == 8'd0)
      else $error("non-hit beat with coordinates");

   // request side stalls only with a word waiting behind a stalled result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff && rsp_valid_ff && rsp_stall)
      else $error("request stalled without a blocked result");

endmodule

// ----- sv/prwd_core.sv -----
// ----------------------------------------------------------------------------
// prwd_core
// Stream framing state and single-pass decode of one registered item.
// ----------------------------------------------------------------------------
module prwd_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,
   input  prwd_pkg::item_type   item,
   output prwd_pkg::result_type result
);
   import prwd_pkg::*;

   logic [6:0]  event_ref_ff,   event_ref_in;
   logic        ref_valid_ff,   ref_valid_in;
   logic        inside_ff,      inside_in;
   logic [12:0] hits_ff,        hits_in;
   logic [3:0]  chip_ff,        chip_in;
   logic [2:0]  stave_ff,       stave_in;
   logic [4:0]  eq_ff,          eq_in;
   logic [5:0]  absent_ff,      absent_in;
   logic [5:0]  expected_ff,    expected_in;
   logic [7:0]  headers_ff,     headers_in;
   logic [7:0]  trailers_ff,    trailers_in;
   logic        phase_ff,       phase_in;
   logic        fill_ff,        fill_in;
   logic        open_ff,        open_in;

   logic [11:0] count_err;
   logic [2:0]  present_cnt;
   logic [5:0]  expected_new;
   logic [1:0]  wtype;
   logic [6:0]  hdr_ec;
   logic [3:0]  hdr_chip;
   logic [2:0]  hdr_hs;
   logic [7:0]  absent_ext;
   logic        chip_hi;
   logic [2:0]  chip_mod5;
   logic [3:0]  slot;

   // per-equipment header and trailer count check
   always_comb begin
      count_err = '0;
      if (headers_ff  != {2'b00, expected_ff}) count_err = count_err | ERR_HDR_CNT;
      if (trailers_ff != {2'b00, expected_ff}) count_err = count_err | ERR_TRL_CNT;
   end

   // ten chips per present half stave
   always_comb begin
      present_cnt = '0;
      for (int h = 0; h < 6; h++) begin
         present_cnt = present_cnt + {2'b00, ~item.absent_mask[h]};
      end
      expected_new = {present_cnt, 3'b000} - {2'b00, present_cnt, 1'b0}
                     + {1'b0, present_cnt, 2'b00};
   end

   // field extraction and hit mapping
   assign wtype      = item.word[15:14];
   assign hdr_ec     = item.word[10:4];
   assign hdr_chip   = item.word[3:0];
   assign hdr_hs     = item.word[13:11];
   assign absent_ext = {2'b00, absent_ff};
   assign chip_hi    = (chip_ff >= ChipsPerHalf);
   assign chip_mod5  = chip_hi ? 3'(chip_ff - ChipsPerHalf) : chip_ff[2:0];
   assign slot       = {stave_ff, 1'b0} + {3'b000, chip_hi};

   // next state and result
   always_comb begin
      event_ref_in = event_ref_ff;
      ref_valid_in = ref_valid_ff;
      inside_in    = inside_ff;
      hits_in      = hits_ff;
      chip_in      = chip_ff;
      stave_in     = stave_ff;
      eq_in        = eq_ff;
      absent_in    = absent_ff;
      expected_in  = expected_ff;
      headers_in   = headers_ff;
      trailers_in  = trailers_ff;
      phase_in     = phase_ff;
      fill_in      = fill_ff;
      open_in      = open_ff;
      result       = '0;
      case (item.kind)
         KIND_START: begin
            if (open_ff && !item.new_event) result.error_flags = count_err;
            if (item.new_event) ref_valid_in = 1'b0;
            if (item.equipment > EqMax) begin
               result.error_flags = result.error_flags | ERR_EQ;
               eq_in = EqMax;
            end else begin
               eq_in = item.equipment;
            end
            absent_in   = item.absent_mask;
            expected_in = expected_new;
            headers_in  = '0;
            trailers_in = '0;
            phase_in    = 1'b0;
            fill_in     = 1'b0;
            inside_in   = 1'b0;
            open_in     = 1'b1;
         end
         KIND_END: begin
            if (open_ff) result.error_flags = count_err;
            open_in = 1'b0;
         end
         KIND_PAYLOAD: begin
            phase_in = ~phase_ff;
            case (wtype)
               WTYPE_HEADER: begin
                  if (inside_ff) result.error_flags = result.error_flags | ERR_TRL_MISS;
                  inside_in = 1'b1;
                  if (headers_ff != HeaderSat) headers_in = headers_ff + 8'd1;
                  hits_in = '0;
                  if (!ref_valid_ff) begin
                     event_ref_in = hdr_ec;
                     ref_valid_in = 1'b1;
                  end else if (hdr_ec != event_ref_ff) begin
                     result.error_flags = result.error_flags | ERR_EVT;
                     event_ref_in = hdr_ec;
                  end
                  if (hdr_chip > ChipMax) begin
                     result.error_flags = result.error_flags | ERR_CHIP;
                     chip_in = '0;
                  end else begin
                     chip_in = hdr_chip;
                  end
                  if (hdr_hs > StaveMax || absent_ext[hdr_hs]) begin
                     result.error_flags = result.error_flags | ERR_HS;
                     stave_in = '0;
                  end else begin
                     stave_in = hdr_hs;
                  end
               end
               WTYPE_TRAILER: begin
                  if (phase_in ^ fill_ff) begin
                     result.error_flags = result.error_flags | ERR_FILL_MISS;
                     fill_in = ~fill_ff;
                  end
                  if (!inside_ff) result.error_flags = result.error_flags | ERR_ORPHAN_TRL;
                  inside_in = 1'b0;
                  if (trailers_ff != HeaderSat) trailers_in = trailers_ff + 8'd1;
                  if (item.word[12:0] != hits_ff) begin
                     result.error_flags = result.error_flags | ERR_HITS;
                  end
               end
               WTYPE_HIT: begin
                  if (!inside_ff) begin
                     result.error_flags = result.error_flags | ERR_HDR_MISS;
                     inside_in = 1'b1;
                  end
                  if (hits_ff != HitSat) hits_in = hits_ff + 13'd1;
                  result.hit_valid  = 1'b1;
                  result.module_res = module_of(eq_ff, slot);
                  result.column     = {chip_mod5, item.word[4:0]};
                  result.pixel_row  = item.word[12:5];
               end
               default: begin
                  // fill word
                  if (!(phase_in ^ fill_ff)) begin
                     result.error_flags = result.error_flags | ERR_FILL_UNEXP;
                     fill_in = ~fill_ff;
                  end
               end
            endcase
         end
         default: begin
         end
      endcase
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         event_ref_ff <= '0;
         ref_valid_ff <= 1'b0;
         inside_ff    <= 1'b0;
         hits_ff      <= '0;
         chip_ff      <= '0;
         stave_ff     <= '0;
         eq_ff        <= EqMax;
         absent_ff    <= '0;
         expected_ff  <= '0;
         headers_ff   <= '0;
         trailers_ff  <= '0;
         phase_ff     <= 1'b0;
         fill_ff      <= 1'b0;
         open_ff      <= 1'b0;
      end else if (fire) begin
         event_ref_ff <= event_ref_in;
         ref_valid_ff <= ref_valid_in;
         inside_ff    <= inside_in;
         hits_ff      <= hits_in;
         chip_ff      <= chip_in;
         stave_ff     <= stave_in;
         eq_ff        <= eq_in;
         absent_ff    <= absent_in;
         expected_ff  <= expected_in;
         headers_ff   <= headers_in;
         trailers_ff  <= trailers_in;
         phase_ff     <= phase_in;
         fill_ff      <= fill_in;
         open_ff      <= open_in;
      end
   end

endmodule
